// ===== sv/bse_pkg.sv =====
// Shared types, constants and the order test of the bubble sort engine.
// Used by the stream interfaces, the sort core and the top level.
package bse_pkg;

	localparam int DATA_W     = 32;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// Register index decoded from paddr[APB_ADDR_W-1:2].
	localparam logic [APB_ADDR_W-3:0] REG_SORT_DESC = 1'b0;

	localparam int ST_W = 3;
	localparam logic [ST_W-1:0] ST_LOAD       = 3'd0;
	localparam logic [ST_W-1:0] ST_SORT_START = 3'd1;
	localparam logic [ST_W-1:0] ST_SORT_FIRST = 3'd2;
	localparam logic [ST_W-1:0] ST_SORT_RUN   = 3'd3;
	localparam logic [ST_W-1:0] ST_SORT_TAIL  = 3'd4;
	localparam logic [ST_W-1:0] ST_EMIT       = 3'd5;

	typedef logic signed [DATA_W-1:0] data_t;

	// True when the lower-addressed element must move past the higher one.
	function automatic logic out_of_order(input logic desc, input data_t first,
		input data_t second);
		return desc ? (second > first) : (first > second);
	endfunction

endpackage

// ===== sv/bse_ifs.sv =====
// Valid/ready stream interfaces for input items and sorted results.
// Depends on bse_pkg for the data width.
interface bse_item_if;
	logic                valid;
	logic                ready;
	bse_pkg::data_t      item_value;
	logic                last_item;

	modport source (output valid, output item_value, output last_item, input ready);
	modport sink   (input valid, input item_value, input last_item, output ready);
endinterface

interface bse_result_if;
	logic                valid;
	logic                ready;
	bse_pkg::data_t      sorted_value;
	logic                last_result;
	logic                overflow;

	modport source (output valid, output sorted_value, output last_result,
		output overflow, input ready);
	modport sink   (input valid, input sorted_value, input last_result,
		input overflow, output ready);
endinterface

// ===== sv/bse_core.sv =====
// Element memory, load/sort/emit sequencer and output register.
// Depends on bse_pkg and the stream interfaces in bse_ifs.sv.
module bse_core #(
	parameter int MAX_ELEMENTS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic sort_desc,
	bse_item_if.sink     items,
	bse_result_if.source results
);
	import bse_pkg::*;

	localparam int CntW = $clog2(MAX_ELEMENTS + 1);
	localparam int IdxW = $clog2(MAX_ELEMENTS);

	logic [ST_W-1:0] state_q;
	logic [CntW-1:0] cnt_q;
	logic            dropped_q;
	logic [IdxW-1:0] last_idx_q;
	logic [IdxW-1:0] pass_end_q;
	logic [IdxW-1:0] cmp_idx_q;
	logic [IdxW-1:0] emit_idx_q;
	data_t           carry_q;
	data_t           rd_data_q;
	data_t           mem [MAX_ELEMENTS];
	logic            rd_pend_q;
	logic            pend_last_q;
	logic            pend_ovf_q;
	logic            out_valid_q;
	data_t           out_value_q;
	logic            out_last_q;
	logic            out_ovf_q;

	logic            item_take;
	logic            has_room;
	logic            swap;
	logic            emit_issue;
	logic            we;
	logic [IdxW-1:0] waddr;
	data_t           wdata;
	logic            re;
	logic [IdxW-1:0] raddr;

	assign items.ready  = (state_q == ST_LOAD);
	assign item_take    = items.valid && items.ready;
	assign has_room     = cnt_q < CntW'(MAX_ELEMENTS);
	assign swap         = out_of_order(sort_desc, carry_q, rd_data_q);
	assign emit_issue   = (state_q == ST_EMIT) && !rd_pend_q &&
		(!out_valid_q || results.ready);

	assign results.valid        = out_valid_q;
	assign results.sorted_value = out_value_q;
	assign results.last_result  = out_last_q;
	assign results.overflow     = out_ovf_q;

	always_comb begin
		we    = 1'b0;
		waddr = cnt_q[IdxW-1:0];
		wdata = items.item_value;
		re    = 1'b0;
		raddr = emit_idx_q;
		unique case (state_q)
			ST_LOAD: begin
				we = item_take && has_room;
			end
			ST_SORT_START: begin
				re    = 1'b1;
				raddr = '0;
			end
			ST_SORT_FIRST: begin
				re    = 1'b1;
				raddr = IdxW'(1);
			end
			ST_SORT_RUN: begin
				we    = 1'b1;
				waddr = cmp_idx_q - IdxW'(1);
				wdata = swap ? rd_data_q : carry_q;
				re    = (cmp_idx_q != pass_end_q);
				raddr = cmp_idx_q + IdxW'(1);
			end
			ST_SORT_TAIL: begin
				we    = 1'b1;
				waddr = pass_end_q;
				wdata = carry_q;
			end
			ST_EMIT: begin
				re = emit_issue;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_data_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			dropped_q   <= 1'b0;
			last_idx_q  <= '0;
			pass_end_q  <= '0;
			cmp_idx_q   <= '0;
			emit_idx_q  <= '0;
			rd_pend_q   <= 1'b0;
			pend_last_q <= 1'b0;
			pend_ovf_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_q <= emit_issue;
			if (rd_pend_q) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (item_take) begin
						if (has_room) begin
							cnt_q <= cnt_q + CntW'(1);
						end else begin
							dropped_q <= 1'b1;
						end
						if (items.last_item) begin
							last_idx_q <= has_room ? cnt_q[IdxW-1:0] : IdxW'(MAX_ELEMENTS - 1);
							pass_end_q <= has_room ? cnt_q[IdxW-1:0] : IdxW'(MAX_ELEMENTS - 1);
							state_q    <= ST_SORT_START;
						end
					end
				end
				ST_SORT_START: begin
					if (pass_end_q == '0) begin
						emit_idx_q <= '0;
						state_q    <= ST_EMIT;
					end else begin
						state_q <= ST_SORT_FIRST;
					end
				end
				ST_SORT_FIRST: begin
					cmp_idx_q <= IdxW'(1);
					state_q   <= ST_SORT_RUN;
				end
				ST_SORT_RUN: begin
					if (cmp_idx_q == pass_end_q) begin
						state_q <= ST_SORT_TAIL;
					end else begin
						cmp_idx_q <= cmp_idx_q + IdxW'(1);
					end
				end
				ST_SORT_TAIL: begin
					pass_end_q <= pass_end_q - IdxW'(1);
					state_q    <= ST_SORT_START;
				end
				ST_EMIT: begin
					if (emit_issue) begin
						pend_last_q <= (emit_idx_q == last_idx_q);
						pend_ovf_q  <= dropped_q;
						if (emit_idx_q == last_idx_q) begin
							cnt_q     <= '0;
							dropped_q <= 1'b0;
							state_q   <= ST_LOAD;
						end else begin
							emit_idx_q <= emit_idx_q + IdxW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// The carry holds the element that bubbles along the current pass.
	always_ff @(posedge clk) begin
		if (state_q == ST_SORT_FIRST) begin
			carry_q <= rd_data_q;
		end else if (state_q == ST_SORT_RUN && !swap) begin
			carry_q <= rd_data_q;
		end
		if (rd_pend_q) begin
			out_value_q <= rd_data_q;
			out_last_q  <= pend_last_q;
			out_ovf_q   <= pend_ovf_q;
		end
	end

	a_load_into_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> !out_valid_q)
		else $error("result loaded while the output register is occupied");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(MAX_ELEMENTS))
		else $error("element count exceeds the memory depth");

	a_drop_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		dropped_q |-> (cnt_q == CntW'(MAX_ELEMENTS)))
		else $error("drop flag set with room left in memory");

	a_pass_in_set: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SORT_RUN) |-> (cmp_idx_q <= pass_end_q && pass_end_q <= last_idx_q))
		else $error("sort pass runs beyond the stored set");

	a_pend_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> ($past(state_q) == ST_EMIT))
		else $error("result read issued outside the emit phase");

endmodule

// ===== sv/bubble_sort_engine.sv =====
// Bubble sort engine: collects signed 32-bit elements of a set into one memory of
// MAX_ELEMENTS entries, one element per cycle, and after the element marked last
// sorts the set in place and sends it out as one run, ascending or descending as the
// sort_descending register (address 0) selects. Elements that arrive while the memory
// is full are dropped and every result of that set carries the overflow flag. The sort
// makes passes of decreasing length over the memory's single read port; the run then
// leaves through a registered read of that port into the output register, and a new
// read waits while one is pending or an unaccepted result sits in that register.
// The input is closed from the last element until the final result has been read out
// of the memory.
module bubble_sort_engine #(
	parameter int MAX_ELEMENTS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [bse_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [bse_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [bse_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	bse_item_if.sink                        items,
	bse_result_if.source                    results
);
	import bse_pkg::*;

	logic sort_desc_q;
	logic reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_SORT_DESC);
	assign prdata  = reg_hit ? APB_DATA_W'(sort_desc_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sort_desc_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			sort_desc_q <= pwdata[0];
		end
	end

	bse_core #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.sort_desc(sort_desc_q),
		.items    (items),
		.results  (results)
	);

endmodule
